@@ hw/rtl/bsc_pkg.sv @@
// shared constants for the barometric sensor compensation block
package bsc_pkg;

    localparam int unsigned OVERSAMPLING = 3;

    localparam int unsigned CFG_IDX_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AC1    = 4'd0,
        REG_AC2    = 4'd1,
        REG_AC3    = 4'd2,
        REG_AC4    = 4'd3,
        REG_AC5    = 4'd4,
        REG_AC6    = 4'd5,
        REG_B_PAIR = 4'd6,
        REG_M_PAIR = 4'd7
    } t_reg_idx;

    localparam logic [15:0] RST_AC1    = 16'd408;
    localparam logic [15:0] RST_AC2    = 16'hFFB8;
    localparam logic [15:0] RST_AC3    = 16'hC7D1;
    localparam logic [15:0] RST_AC4    = 16'd32741;
    localparam logic [15:0] RST_AC5    = 16'd32757;
    localparam logic [15:0] RST_AC6    = 16'd23153;
    localparam logic [31:0] RST_B_PAIR = 32'h182E0004;
    localparam logic [31:0] RST_M_PAIR = 32'hDDF90B34;

    localparam logic [31:0] B6_OFFSET  = 32'd4000;
    localparam logic [31:0] B4_BIAS    = 32'd32768;
    localparam logic [31:0] PMUL_BASE  = 32'd50000;
    localparam logic [31:0] PF_SQ_GAIN = 32'd3038;
    localparam logic [31:0] PF_LIN     = 32'hFFFFE343;
    localparam logic [31:0] PF_BIAS    = 32'd3791;

    localparam logic signed [31:0] T_MAX = 32'sd32767;
    localparam logic signed [31:0] T_MIN = -32'sd32768;
    localparam logic signed [31:0] P_MAX = 32'sd262143;

endpackage

@@ hw/rtl/barometric_sensor_compensation.sv @@
// barometric temperature and pressure compensation, fully pipelined
// the temperature and pressure dividers are pipelined, 27-stage and 32-stage
// throughput: one reading pair per cycle while the output is not stalled
// the whole pipeline advances together; a stalled output beat holds every stage
// reset: synchronous active low, clears valid bits and loads calibration defaults
// calibration registers are plain flops, ready is always high
module barometric_sensor_compensation #(
    parameter int unsigned OVERSAMPLING = bsc_pkg::OVERSAMPLING
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [15:0]                     i_raw_temperature,
    input  logic [18:0]                     i_raw_pressure,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [15:0]              o_temperature_tenths,
    output logic [17:0]                     o_pressure_pascal,
    output logic                            o_divide_fault,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                     i_cfg_data
);

    localparam int unsigned OS     = OVERSAMPLING;
    localparam logic [31:0] PMUL   = bsc_pkg::PMUL_BASE >> OS;
    localparam int unsigned D1_NW  = 27;
    localparam int unsigned D1_SW  = 1 + 1 + 32 + 19;
    localparam int unsigned D2_NW  = 32;
    localparam int unsigned D2_SW  = 1 + 1 + 32;

    // calibration registers
    logic [15:0] r_ac1, r_ac2, r_ac3, r_ac4, r_ac5, r_ac6;
    logic [31:0] r_b_pair, r_m_pair;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac1    <= bsc_pkg::RST_AC1;
            r_ac2    <= bsc_pkg::RST_AC2;
            r_ac3    <= bsc_pkg::RST_AC3;
            r_ac4    <= bsc_pkg::RST_AC4;
            r_ac5    <= bsc_pkg::RST_AC5;
            r_ac6    <= bsc_pkg::RST_AC6;
            r_b_pair <= bsc_pkg::RST_B_PAIR;
            r_m_pair <= bsc_pkg::RST_M_PAIR;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bsc_pkg::REG_AC1:    r_ac1    <= i_cfg_data[15:0];
                bsc_pkg::REG_AC2:    r_ac2    <= i_cfg_data[15:0];
                bsc_pkg::REG_AC3:    r_ac3    <= i_cfg_data[15:0];
                bsc_pkg::REG_AC4:    r_ac4    <= i_cfg_data[15:0];
                bsc_pkg::REG_AC5:    r_ac5    <= i_cfg_data[15:0];
                bsc_pkg::REG_AC6:    r_ac6    <= i_cfg_data[15:0];
                bsc_pkg::REG_B_PAIR: r_b_pair <= i_cfg_data;
                bsc_pkg::REG_M_PAIR: r_m_pair <= i_cfg_data;
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // coefficients widened to 32 bits
    logic [31:0] w_ac1, w_ac2, w_ac3, w_ac4, w_ac5, w_ac6;
    logic [31:0] w_b1, w_b2, w_mc, w_md;

    assign w_ac1 = {{16{r_ac1[15]}}, r_ac1};
    assign w_ac2 = {{16{r_ac2[15]}}, r_ac2};
    assign w_ac3 = {{16{r_ac3[15]}}, r_ac3};
    assign w_ac4 = {16'd0, r_ac4};
    assign w_ac5 = {16'd0, r_ac5};
    assign w_ac6 = {16'd0, r_ac6};
    assign w_b1  = {{16{r_b_pair[31]}}, r_b_pair[31:16]};
    assign w_b2  = {{16{r_b_pair[15]}}, r_b_pair[15:0]};
    assign w_mc  = {{16{r_m_pair[31]}}, r_m_pair[31:16]};
    assign w_md  = {{16{r_m_pair[15]}}, r_m_pair[15:0]};

    // global advance: the pipeline moves unless the output beat is held
    logic w_adv;
    logic r_ov;
    logic r11_v;

    assign w_adv      = !r_ov || !i_out_stall;
    assign o_in_stall = !w_adv;

    // stage 1: (ut - ac6) * ac5
    logic [31:0] w1_d, w1_prod;
    logic [31:0] r1_prod;
    logic [18:0] r1_up;
    logic        r1_v;

    assign w1_d    = {16'd0, i_raw_temperature} - w_ac6;
    assign w1_prod = w1_d * w_ac5;

    // stage 2: x1 and temperature divisor
    logic signed [31:0] w2_x1;
    logic [31:0]        r2_x1, r2_den;
    logic [18:0]        r2_up;
    logic               r2_v;

    assign w2_x1 = $signed(r1_prod) >>> 15;

    // stage 3: magnitudes and quotient sign for mc * 2048 / den
    logic [31:0] w3_num;
    logic [26:0] r3_nabs;
    logic [31:0] r3_dabs;
    logic        r3_neg, r3_flt;
    logic [31:0] r3_x1;
    logic [18:0] r3_up;
    logic        r3_v;

    assign w3_num = w_mc << 11;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (w_adv) begin
            r1_v <= i_in_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_prod <= w1_prod;
            r1_up   <= i_raw_pressure;
            r2_x1   <= w2_x1;
            r2_den  <= w2_x1 + w_md;
            r2_up   <= r1_up;
            r3_nabs <= w3_num[31] ? 27'(-w3_num) : w3_num[26:0];
            r3_dabs <= r2_den[31] ? -r2_den : r2_den;
            r3_neg  <= w3_num[31] ^ r2_den[31];
            r3_flt  <= (r2_den == 32'd0);
            r3_x1   <= r2_x1;
            r3_up   <= r2_up;
        end
    end

    // temperature divider
    logic             w_d1_v;
    logic [D1_NW-1:0] w_d1_q;
    logic [D1_SW-1:0] w_d1_s;

    bsc_div #(.NW(D1_NW), .DW(32), .SW(D1_SW)) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (r3_v),
        .i_num   (r3_nabs),
        .i_den   (r3_dabs),
        .i_side  ({r3_neg, r3_flt, r3_x1, r3_up}),
        .o_vld   (w_d1_v),
        .o_quo   (w_d1_q),
        .o_side  (w_d1_s)
    );

    logic        w4_neg, w4_flt;
    logic [31:0] w4_x1, w4_q, w4_b5;
    logic [18:0] w4_up;

    assign {w4_neg, w4_flt, w4_x1, w4_up} = w_d1_s;
    assign w4_q  = w4_neg ? -{5'd0, w_d1_q} : {5'd0, w_d1_q};
    assign w4_b5 = w4_x1 + w4_q;

    // stage 4: b5, b6
    logic [31:0] r4_b5, r4_b6;
    logic        r4_flt, r4_v;
    logic [18:0] r4_up;

    // stage 5: b6 products
    logic [31:0] r5_sq, r5_a2, r5_a3, r5_b5;
    logic        r5_flt, r5_v;
    logic [18:0] r5_up;

    // stage 6: b6sq products
    logic signed [31:0] w6_b6sq;
    logic [31:0]        r6_pb2, r6_pb1, r6_x1a, r6_x1c, r6_b5;
    logic               r6_flt, r6_v;
    logic [18:0]        r6_up;

    assign w6_b6sq = $signed(r5_sq) >>> 12;

    // stage 7: b3 and the b4 operand
    logic signed [31:0] w7_x3a, w7_pre, w7_x3b;
    logic [31:0]        r7_b3, r7_t, r7_b5;
    logic               r7_flt, r7_v;
    logic [18:0]        r7_up;

    assign w7_x3a = ($signed(r6_pb2) >>> 11) + $signed(r6_x1a);
    assign w7_pre = (((w_ac1 << 2) + w7_x3a) << OS) + 32'd2;
    assign w7_x3b = ($signed(r6_x1c) + ($signed(r6_pb1) >>> 16) + 32'sd2) >>> 2;

    // stage 8: b4 and b7
    logic [31:0] w8_b4p;
    logic [31:0] r8_b4, r8_b7, r8_b5;
    logic        r8_flt, r8_v;

    assign w8_b4p = w_ac4 * r7_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
        end else if (w_adv) begin
            r4_v <= w_d1_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
            r8_v <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_b5  <= w4_b5;
            r4_b6  <= w4_b5 - bsc_pkg::B6_OFFSET;
            r4_flt <= w4_flt;
            r4_up  <= w4_up;

            r5_sq  <= r4_b6 * r4_b6;
            r5_a2  <= w_ac2 * r4_b6;
            r5_a3  <= w_ac3 * r4_b6;
            r5_b5  <= r4_b5;
            r5_flt <= r4_flt;
            r5_up  <= r4_up;

            r6_pb2 <= w_b2 * w6_b6sq;
            r6_pb1 <= w_b1 * w6_b6sq;
            r6_x1a <= $signed(r5_a2) >>> 11;
            r6_x1c <= $signed(r5_a3) >>> 13;
            r6_b5  <= r5_b5;
            r6_flt <= r5_flt;
            r6_up  <= r5_up;

            r7_b3  <= w7_pre >>> 2;
            r7_t   <= w7_x3b + bsc_pkg::B4_BIAS;
            r7_b5  <= r6_b5;
            r7_flt <= r6_flt;
            r7_up  <= r6_up;

            r8_b4  <= w8_b4p >> 15;
            r8_b7  <= ({13'd0, r7_up} - r7_b3) * PMUL;
            r8_b5  <= r7_b5;
            r8_flt <= r7_flt;
        end
    end

    // pressure divider; a large b7 is divided before doubling
    logic [31:0] w9_num;
    logic        w9_flt;

    assign w9_num = r8_b7[31] ? r8_b7 : (r8_b7 << 1);
    assign w9_flt = r8_flt || (r8_b4 == 32'd0);

    logic             w_d2_v;
    logic [D2_NW-1:0] w_d2_q;
    logic [D2_SW-1:0] w_d2_s;

    bsc_div #(.NW(D2_NW), .DW(32), .SW(D2_SW)) u_div_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (r8_v),
        .i_num   (w9_num),
        .i_den   (r8_b4),
        .i_side  ({r8_b7[31], w9_flt, r8_b5}),
        .o_vld   (w_d2_v),
        .o_quo   (w_d2_q),
        .o_side  (w_d2_s)
    );

    logic        w10_big, w10_flt;
    logic [31:0] w10_b5, w10_p;
    logic signed [31:0] w10_pp;

    assign {w10_big, w10_flt, w10_b5} = w_d2_s;
    assign w10_p  = w10_big ? (w_d2_q << 1) : w_d2_q;
    assign w10_pp = $signed(w10_p) >>> 8;

    // stage 10: p squared and linear term
    logic [31:0] r10_sq, r10_m7, r10_p, r10_b5;
    logic        r10_flt, r10_v;

    // stage 11: square term gain
    logic [31:0] r11_m3, r11_x2, r11_p, r11_b5;
    logic        r11_flt;

    // stage 12: final sums and saturation
    logic signed [31:0] w12_pf, w12_t;

    assign w12_pf = $signed(r11_p)
                  + (((($signed(r11_m3) >>> 16) + $signed(r11_x2)) + $signed(bsc_pkg::PF_BIAS))
                     >>> 4);
    assign w12_t  = $signed(r11_b5 + 32'd8) >>> 4;

    logic signed [15:0] r_ot;
    logic [17:0]        r_op;
    logic               r_of;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_v <= 1'b0;
            r11_v <= 1'b0;
            r_ov  <= 1'b0;
        end else if (w_adv) begin
            r10_v <= w_d2_v;
            r11_v <= r10_v;
            r_ov  <= r11_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r10_sq  <= w10_pp * w10_pp;
            r10_m7  <= bsc_pkg::PF_LIN * w10_p;
            r10_p   <= w10_p;
            r10_b5  <= w10_b5;
            r10_flt <= w10_flt;

            r11_m3  <= r10_sq * bsc_pkg::PF_SQ_GAIN;
            r11_x2  <= $signed(r10_m7) >>> 16;
            r11_p   <= r10_p;
            r11_b5  <= r10_b5;
            r11_flt <= r10_flt;

            r_of <= r11_flt;
            if (r11_flt) begin
                r_ot <= '0;
                r_op <= '0;
            end else begin
                if (w12_t > bsc_pkg::T_MAX) begin
                    r_ot <= 16'sh7FFF;
                end else if (w12_t < bsc_pkg::T_MIN) begin
                    r_ot <= 16'sh8000;
                end else begin
                    r_ot <= w12_t[15:0];
                end
                if (w12_pf < 32'sd0) begin
                    r_op <= '0;
                end else if (w12_pf > bsc_pkg::P_MAX) begin
                    r_op <= '1;
                end else begin
                    r_op <= w12_pf[17:0];
                end
            end
        end
    end

    assign o_out_valid          = r_ov;
    assign o_temperature_tenths = r_ot;
    assign o_pressure_pascal    = r_op;
    assign o_divide_fault       = r_of;

endmodule

@@ hw/rtl/bsc_div.sv @@
// pipelined restoring unsigned divider, one quotient bit per stage
module bsc_div #(
    parameter int unsigned NW = 32,
    parameter int unsigned DW = 32,
    parameter int unsigned SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [NW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic [DW-1:0] w_rem  [0:NW];
    logic [NW-1:0] w_num  [0:NW];
    logic [NW-1:0] w_quo  [0:NW];
    logic [DW-1:0] w_den  [0:NW];
    logic [SW-1:0] w_side [0:NW];
    logic          w_vld  [0:NW];

    assign w_rem[0]  = '0;
    assign w_num[0]  = i_num;
    assign w_quo[0]  = '0;
    assign w_den[0]  = i_den;
    assign w_side[0] = i_side;
    assign w_vld[0]  = i_vld;

    for (genvar g = 0; g < NW; g++) begin : g_stage
        logic [DW:0]   w_trial;
        logic          w_ge;
        logic [DW:0]   w_diff;
        logic [DW-1:0] r_rem;
        logic [NW-1:0] r_num;
        logic [NW-1:0] r_quo;
        logic [DW-1:0] r_den;
        logic [SW-1:0] r_side;
        logic          r_vld;

        assign w_trial = {w_rem[g], w_num[g][NW-1]};
        assign w_ge    = (w_trial >= {1'b0, w_den[g]});
        assign w_diff  = w_trial - {1'b0, w_den[g]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
                r_num  <= w_num[g] << 1;
                r_quo  <= (w_quo[g] << 1) | NW'(w_ge);
                r_den  <= w_den[g];
                r_side <= w_side[g];
            end
        end

        assign w_rem[g+1]  = r_rem;
        assign w_num[g+1]  = r_num;
        assign w_quo[g+1]  = r_quo;
        assign w_den[g+1]  = r_den;
        assign w_side[g+1] = r_side;
        assign w_vld[g+1]  = r_vld;
    end

    assign o_vld  = w_vld[NW];
    assign o_quo  = w_quo[NW];
    assign o_side = w_side[NW];

endmodule

@@ tb/sv/tb_barometric_sensor_compensation.sv @@
// testbench for barometric_sensor_compensation: random and directed readings, self-checking
`timescale 1ns / 100ps

module tb_barometric_sensor_compensation;

    // out-of-range register index, the block must drop writes to it
    localparam logic [bsc_pkg::CFG_IDX_W-1:0] REG_NONE = 4'hF;
    // drain wait after the last result, a bit over the pipeline depth
    localparam int DRAIN_CYCLES = 80;
    // long receiver hold-off, several pipeline depths
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [15:0] ut;
        logic [18:0] up;
    } t_reading;

    typedef struct packed {
        logic signed [15:0] temp;
        logic [17:0]        pres;
        logic               fault;
    } t_comp;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [15:0]                   i_raw_temperature;
    logic [18:0]                   i_raw_pressure;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic signed [15:0]            o_temperature_tenths;
    logic [17:0]                   o_pressure_pascal;
    logic                          o_divide_fault;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [bsc_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]                   i_cfg_data;

    barometric_sensor_compensation u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_raw_temperature    (i_raw_temperature),
        .i_raw_pressure       (i_raw_pressure),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_temperature_tenths (o_temperature_tenths),
        .o_pressure_pascal    (o_pressure_pascal),
        .o_divide_fault       (o_divide_fault),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    // calibration as the testbench believes it is loaded
    logic [15:0] cal_ac1, cal_ac2, cal_ac3, cal_ac4, cal_ac5, cal_ac6;
    logic [31:0] cal_b_pair, cal_m_pair;

    t_reading readings_pending[$];
    t_comp    comp_expected[$];

    int  send_idle_pct;
    int  out_stall_pct;
    bit  in_taken;
    bit  hold_go;
    bit  hold_busy;
    int  hold_left;
    int  mismatches;
    int  cycles;
    int  n_in, n_out, n_fault, n_tsat, n_psat, n_backpressure;

    function automatic logic [31:0] sra(logic [31:0] v, int n);
        return $signed(v) >>> n;
    endfunction

    function automatic logic [31:0] sx16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // integer compensation, 32-bit wrapping arithmetic
    function automatic t_comp compensate(logic [15:0] ut16, logic [18:0] up19);
        logic [31:0] ut, up, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] x1, x2, x3, den, num, b5, b6, b6sq, b3, b4, b7, p, pf, t;
        t_comp r;
        r = '{temp: '0, pres: '0, fault: 1'b1};
        ut  = {16'd0, ut16};
        up  = {13'd0, up19};
        ac1 = sx16(cal_ac1);
        ac2 = sx16(cal_ac2);
        ac3 = sx16(cal_ac3);
        ac4 = {16'd0, cal_ac4};
        ac5 = {16'd0, cal_ac5};
        ac6 = {16'd0, cal_ac6};
        b1  = sx16(cal_b_pair[31:16]);
        b2  = sx16(cal_b_pair[15:0]);
        mc  = sx16(cal_m_pair[31:16]);
        md  = sx16(cal_m_pair[15:0]);

        // temperature
        x1  = sra((ut - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 0) return r;
        num = mc << 11;
        x2  = $signed(num) / $signed(den);
        b5  = x1 + x2;

        // pressure
        b6   = b5 - bsc_pkg::B6_OFFSET;
        b6sq = sra(b6 * b6, 12);
        x1   = sra(b2 * b6sq, 11);
        x2   = sra(ac2 * b6, 11);
        x3   = x1 + x2;
        b3   = sra(((ac1 * 32'd4 + x3) << bsc_pkg::OVERSAMPLING) + 32'd2, 2);
        x1   = sra(ac3 * b6, 13);
        x2   = sra(b1 * b6sq, 16);
        x3   = sra(x1 + x2 + 32'd2, 2);
        b4   = (ac4 * (x3 + bsc_pkg::B4_BIAS)) >> 15;
        if (b4 == 0) return r;
        b7 = (up - b3) * (bsc_pkg::PMUL_BASE >> bsc_pkg::OVERSAMPLING);
        if (!b7[31]) p = (b7 << 1) / b4;
        else         p = (b7 / b4) << 1;
        x1 = sra(p, 8) * sra(p, 8);
        x1 = sra(x1 * bsc_pkg::PF_SQ_GAIN, 16);
        x2 = sra(bsc_pkg::PF_LIN * p, 16);
        pf = p + sra(x1 + x2 + bsc_pkg::PF_BIAS, 4);

        t = sra(b5 + 32'd8, 4);
        if ($signed(t) > bsc_pkg::T_MAX)      r.temp = 16'sh7FFF;
        else if ($signed(t) < bsc_pkg::T_MIN) r.temp = 16'sh8000;
        else                                  r.temp = t[15:0];
        if ($signed(pf) > bsc_pkg::P_MAX)     r.pres = 18'h3FFFF;
        else if ($signed(pf) < 0)             r.pres = '0;
        else                                  r.pres = pf[17:0];
        r.fault = 1'b0;
        return r;
    endfunction

    // clock and cycle limit
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // sender: a new beat only once the previous one has gone in
    always @(negedge i_clk) begin : drive_readings
        t_reading nxt;
        if (!i_in_valid || in_taken) begin
            if (readings_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = readings_pending.pop_front();
                i_in_valid        <= 1'b1;
                i_raw_temperature <= nxt.ut;
                i_raw_pressure    <= nxt.up;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall, forced high during the long hold-off
    always @(negedge i_clk) begin
        i_out_stall <= (hold_left != 0) || ($urandom_range(99) < out_stall_pct);
    end

    // hold-off counter
    always @(posedge i_clk) begin
        if (!hold_go) begin
            hold_busy <= 1'b0;
        end else if (!hold_busy) begin
            hold_left <= HOLD_CYCLES;
            hold_busy <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // input beat acceptance: predict the result with the loaded calibration
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            comp_expected.push_back(compensate(i_raw_temperature, i_raw_pressure));
            n_in <= n_in + 1;
        end
        if (i_rst_n && i_in_valid && o_in_stall) n_backpressure <= n_backpressure + 1;
    end

    // output beat check against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_comp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_out <= n_out + 1;
            if (comp_expected.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result beat: temp %0d pres %0d fault %0b",
                             o_temperature_tenths, o_pressure_pascal, o_divide_fault);
            end else begin
                want = comp_expected.pop_front();
                if (want.fault) n_fault <= n_fault + 1;
                if (!want.fault && (want.temp == 16'sh7FFF || want.temp == 16'sh8000))
                    n_tsat <= n_tsat + 1;
                if (!want.fault && (want.pres == 18'h3FFFF || want.pres == 0))
                    n_psat <= n_psat + 1;
                if (o_temperature_tenths !== want.temp || o_pressure_pascal !== want.pres
                    || o_divide_fault !== want.fault) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: temp %0d/%0d pres %0d/%0d fault %0b/%0b (exp/act)",
                                 want.temp, o_temperature_tenths, want.pres,
                                 o_pressure_pascal, want.fault, o_divide_fault);
                end
            end
        end
    end

    task automatic write_reg(logic [bsc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            bsc_pkg::REG_AC1:    cal_ac1    = data[15:0];
            bsc_pkg::REG_AC2:    cal_ac2    = data[15:0];
            bsc_pkg::REG_AC3:    cal_ac3    = data[15:0];
            bsc_pkg::REG_AC4:    cal_ac4    = data[15:0];
            bsc_pkg::REG_AC5:    cal_ac5    = data[15:0];
            bsc_pkg::REG_AC6:    cal_ac6    = data[15:0];
            bsc_pkg::REG_B_PAIR: cal_b_pair = data;
            bsc_pkg::REG_M_PAIR: cal_m_pair = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_cal(logic [15:0] a1, a2, a3, a4, a5, a6, logic [31:0] bp, mp);
        write_reg(bsc_pkg::REG_AC1, {16'd0, a1});
        write_reg(bsc_pkg::REG_AC2, {16'd0, a2});
        write_reg(bsc_pkg::REG_AC3, {16'd0, a3});
        write_reg(bsc_pkg::REG_AC4, {16'd0, a4});
        write_reg(bsc_pkg::REG_AC5, {16'd0, a5});
        write_reg(bsc_pkg::REG_AC6, {16'd0, a6});
        write_reg(bsc_pkg::REG_B_PAIR, bp);
        write_reg(bsc_pkg::REG_M_PAIR, mp);
    endtask

    // queue random readings, then wait until the pipeline is empty
    task automatic run_readings(int n, int idle_pct, int stall_pct);
        t_reading rd;
        send_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(3) == 0) begin
                rd.ut = 16'($urandom);
                rd.up = 19'($urandom);
            end else begin
                // plausible sensor range
                rd.ut = 16'($urandom_range(35000, 20000));
                rd.up = 19'($urandom_range(45000, 25000) << bsc_pkg::OVERSAMPLING);
            end
            readings_pending.push_back(rd);
        end
        do @(posedge i_clk);
        while (readings_pending.size() != 0 || i_in_valid || comp_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_reading(logic [15:0] ut, logic [18:0] up);
        readings_pending.push_back('{ut: ut, up: up});
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_raw_temperature = '0;
        i_raw_pressure = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        send_idle_pct = 0;
        out_stall_pct = 0;
        hold_go = 1'b0;
        cal_ac1 = bsc_pkg::RST_AC1;
        cal_ac2 = bsc_pkg::RST_AC2;
        cal_ac3 = bsc_pkg::RST_AC3;
        cal_ac4 = bsc_pkg::RST_AC4;
        cal_ac5 = bsc_pkg::RST_AC5;
        cal_ac6 = bsc_pkg::RST_AC6;
        cal_b_pair = bsc_pkg::RST_B_PAIR;
        cal_m_pair = bsc_pkg::RST_M_PAIR;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset calibration: field extremes and typical readings
        push_reading(16'h0000, 19'h00000);
        push_reading(16'hFFFF, 19'h7FFFF);
        push_reading(16'h0000, 19'h7FFFF);
        push_reading(16'hFFFF, 19'h00000);
        push_reading(16'd27898, 19'd23843);
        push_reading(16'd27898, 19'd190744);
        push_reading(16'd1, 19'd1);
        push_reading(16'h8000, 19'h40000);
        push_reading(16'h7FFF, 19'h3FFFF);
        push_reading(16'd23153, 19'd300000);
        run_readings(170, 0, 0);

        // perturbed calibration, plus a write to an unused index that must be dropped
        load_cal(16'(16'd408 + $urandom_range(60)), 16'(16'hFFB8 - $urandom_range(40)),
                 16'(16'hC7D1 + $urandom_range(500)), 16'(16'd32741 - $urandom_range(300)),
                 16'(16'd32757 - $urandom_range(300)), 16'(16'd23153 + $urandom_range(300)),
                 32'h182E0004 + $urandom_range(7), 32'hDDF90B34 + $urandom_range(99));
        write_reg(REG_NONE, 32'h0000_0000);
        run_readings(150, 70, 0);

        // temperature divisor zero: ac5 = 0 and md = 0
        load_cal(16'd408, 16'hFFB8, 16'hC7D1, 16'd32741, 16'd0, 16'd23153,
                 32'h182E0004, 32'hDDF90000);
        push_reading(16'hFFFF, 19'h7FFFF);
        run_readings(20, 0, 70);

        // pressure divisor zero: ac4 = 0
        load_cal(16'd408, 16'hFFB8, 16'hC7D1, 16'd0, 16'd32757, 16'd23153,
                 32'h182E0004, 32'hDDF90B34);
        push_reading(16'd0, 19'd0);
        run_readings(20, 21, 21);

        // temperature saturation high then low: divisor of one, extreme mc
        load_cal(16'd408, 16'hFFB8, 16'hC7D1, 16'd32741, 16'd0, 16'd23153,
                 32'h182E0004, 32'h7FFF0001);
        run_readings(30, 0, 0);
        write_reg(bsc_pkg::REG_M_PAIR, 32'h80000001);
        run_readings(30, 70, 0);

        // all coefficients at their minimum (ac4 at one), then at their maximum
        load_cal(16'h8000, 16'h8000, 16'h8000, 16'h0001, 16'h0000, 16'h0000,
                 32'h80008000, 32'h80008000);
        push_reading(16'hFFFF, 19'h7FFFF);
        run_readings(30, 0, 70);
        load_cal(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 32'h7FFF7FFF, 32'h7FFF7FFF);
        push_reading(16'h0000, 19'h00000);
        run_readings(30, 21, 21);

        // fully random calibrations across the idling patterns
        for (int k = 0; k < 4; k++) begin
            load_cal(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), $urandom, $urandom);
            case (k)
                0: run_readings(60, 0, 0);
                1: run_readings(60, 70, 0);
                2: run_readings(60, 0, 70);
                default: run_readings(60, 21, 21);
            endcase
        end

        // reset calibration again, long receiver hold-off while the sender keeps going
        load_cal(bsc_pkg::RST_AC1, bsc_pkg::RST_AC2, bsc_pkg::RST_AC3, bsc_pkg::RST_AC4,
                 bsc_pkg::RST_AC5, bsc_pkg::RST_AC6, bsc_pkg::RST_B_PAIR, bsc_pkg::RST_M_PAIR);
        @(negedge i_clk);
        hold_go = 1'b1;
        run_readings(120, 0, 0);
        @(negedge i_clk);
        hold_go = 1'b0;

        $display("covered %0d readings, %0d results: %0d divide faults, %0d temp clamps,",
                 n_in, n_out, n_fault, n_tsat);
        $display("%0d pressure clamps, %0d input stall cycles, %0d mismatches",
                 n_psat, n_backpressure, mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        mismatches = 0;
        cycles = 0;
        hold_left = 0;
        hold_busy = 1'b0;
        in_taken = 1'b0;
        n_in = 0;
        n_out = 0;
        n_fault = 0;
        n_tsat = 0;
        n_psat = 0;
        n_backpressure = 0;
    end

endmodule

@@ barometric_sensor_compensation.f @@
hw/rtl/bsc_pkg.sv
hw/rtl/bsc_div.sv
hw/rtl/barometric_sensor_compensation.sv
tb/sv/tb_barometric_sensor_compensation.sv
